@@ hw/rtl/tpm_pkg.sv @@
// shared widths, register map, pipeline payload types and the divider step
package tpm_pkg;

  localparam int RAW_W      = 12;
  localparam int PIX_W      = 10;
  localparam int PROD_W     = RAW_W + PIX_W;
  localparam int Q_W        = PIX_W;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEP;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  localparam logic [RAW_W-1:0] X_LOW_RST  = RAW_W'(200);
  localparam logic [RAW_W-1:0] X_HIGH_RST = RAW_W'(3900);
  localparam logic [RAW_W-1:0] Y_LOW_RST  = RAW_W'(200);
  localparam logic [RAW_W-1:0] Y_HIGH_RST = RAW_W'(3900);
  localparam logic [PIX_W-1:0] WIDTH_RST  = PIX_W'(320);
  localparam logic [PIX_W-1:0] HEIGHT_RST = PIX_W'(240);

  typedef enum logic [2:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0] x_low;
    logic [RAW_W-1:0] x_high;
    logic [RAW_W-1:0] y_low;
    logic [RAW_W-1:0] y_high;
    logic [PIX_W-1:0] width;
    logic [PIX_W-1:0] height;
  } cfg_t;

  // one division in flight: partial remainder, unconsumed dividend bits, quotient
  typedef struct packed {
    logic [RAW_W-1:0] rem;
    logic [Q_W-1:0]   lo;
    logic [Q_W-1:0]   quo;
    logic [RAW_W-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        lx;
    div_lane_t        ly;
    logic [PIX_W-1:0] height;
    logic             err;
  } div_item_t;

  // restoring division, DIV_STEP quotient bits
  function automatic div_lane_t div_step(div_lane_t a);
    div_lane_t      l;
    logic [RAW_W:0] r;
    logic [RAW_W:0] d;
    l = a;
    for (int i = 0; i < DIV_STEP; i++) begin
      r    = {l.rem, l.lo[Q_W-1]};
      l.lo = {l.lo[Q_W-2:0], 1'b0};
      if (r >= {1'b0, l.dvs}) begin
        d     = r - {1'b0, l.dvs};
        l.rem = d[RAW_W-1:0];
        l.quo = {l.quo[Q_W-2:0], 1'b1};
      end else begin
        l.rem = r[RAW_W-1:0];
        l.quo = {l.quo[Q_W-2:0], 1'b0};
      end
    end
    return l;
  endfunction

endpackage

@@ hw/rtl/tpm_if.sv @@
// valid/ready channel interfaces for raw readings and pixel results
interface tpm_in_if import tpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_x;
  logic [RAW_W-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

interface tpm_out_if import tpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic             span_error;

  modport source (output valid, output pixel_x, output pixel_y, output span_error,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input span_error,
                  output ready);
endinterface

@@ hw/rtl/tpm_cfg_regs.sv @@
// apb calibration register file
module tpm_cfg_regs import tpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_X_LOW:  cfg_nxt.x_low  = cfg_pwdata[RAW_W-1:0];
        REG_X_HIGH: cfg_nxt.x_high = cfg_pwdata[RAW_W-1:0];
        REG_Y_LOW:  cfg_nxt.y_low  = cfg_pwdata[RAW_W-1:0];
        REG_Y_HIGH: cfg_nxt.y_high = cfg_pwdata[RAW_W-1:0];
        REG_WIDTH:  cfg_nxt.width  = cfg_pwdata[PIX_W-1:0];
        REG_HEIGHT: cfg_nxt.height = cfg_pwdata[PIX_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_LOW:  cfg_prdata = CFG_DW'(cfg_r.x_low);
      REG_X_HIGH: cfg_prdata = CFG_DW'(cfg_r.x_high);
      REG_Y_LOW:  cfg_prdata = CFG_DW'(cfg_r.y_low);
      REG_Y_HIGH: cfg_prdata = CFG_DW'(cfg_r.y_high);
      REG_WIDTH:  cfg_prdata = CFG_DW'(cfg_r.width);
      REG_HEIGHT: cfg_prdata = CFG_DW'(cfg_r.height);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_low  <= X_LOW_RST;
      cfg_r.x_high <= X_HIGH_RST;
      cfg_r.y_low  <= Y_LOW_RST;
      cfg_r.y_high <= Y_HIGH_RST;
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/tpm_div_pipe.sv @@
// pipelined restoring divider, two quotient bits per stage, both axes side by side
module tpm_div_pipe import tpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_item_t dn_item
);

  logic      vld_r [DIV_STAGES];
  div_item_t item_r[DIV_STAGES];
  logic      rdy   [DIV_STAGES+1];
  logic      src_vld [DIV_STAGES];
  div_item_t src_item[DIV_STAGES];

  assign rdy[DIV_STAGES] = dn_ready;
  assign up_ready        = rdy[0];
  assign dn_valid        = vld_r[DIV_STAGES-1];
  assign dn_item         = item_r[DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src_vld[k]  = up_valid;
      assign src_item[k] = up_item;
    end else begin : g_rest
      assign src_vld[k]  = vld_r[k-1];
      assign src_item[k] = item_r[k-1];
    end

    // a slot takes new data when empty or when its content moves on
    assign rdy[k] = ~vld_r[k] | rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld[k]) begin
        item_r[k].lx     <= div_step(src_item[k].lx);
        item_r[k].ly     <= div_step(src_item[k].ly);
        item_r[k].height <= src_item[k].height;
        item_r[k].err    <= src_item[k].err;
      end
    end
  end

endmodule

@@ hw/rtl/touch_raw_to_pixel_mapper_core.sv @@
// touch raw-to-pixel mapper: clamp, scale by screen size, divide by raw span
// pipeline: a raw pair accepted from in_ch reaches its result on out_ch through
//   eight register stages: clamp, multiply, five divider stages at two quotient
//   bits each, output register; the clamp register loads at the accepting edge
// throughput: one item per cycle; every stage holds independently under back-pressure
// reset: synchronous active-low rst_n empties the pipeline and loads the default
//   calibration 200..3900 on both axes, 320 by 240 pixels
module touch_raw_to_pixel_mapper_core import tpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tpm_in_if.sink            in_ch,
  tpm_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  tpm_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // stage 1: clamp into the raw window and remove the offset
  logic             s1_vld_r;
  logic             s1_rdy;
  logic [RAW_W-1:0] s1_cx_r, s1_cy_r, s1_xspan_r, s1_yspan_r;
  logic [PIX_W-1:0] s1_w_r, s1_h_r;
  logic             s1_err_r;
  logic [RAW_W-1:0] cx_nxt, cy_nxt;

  // stage 2: products, set up as divider lanes
  logic      s2_vld_r;
  logic      s2_rdy;
  div_item_t s2_item_r;
  logic [PROD_W-1:0] prod_x, prod_y;

  // divider
  logic      dv_vld;
  logic      dv_rdy;
  div_item_t dv_item;

  // output register
  logic             o_vld_r;
  logic             o_rdy;
  logic [PIX_W-1:0] o_px_r, o_py_r;
  logic             o_err_r;

  assign o_rdy    = ~o_vld_r | out_ch.ready;
  assign s2_rdy   = ~s2_vld_r | dv_rdy;
  assign s1_rdy   = ~s1_vld_r | s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_comb begin
    if (in_ch.raw_x < cfg.x_low)       cx_nxt = '0;
    else if (in_ch.raw_x > cfg.x_high) cx_nxt = cfg.x_high - cfg.x_low;
    else                               cx_nxt = in_ch.raw_x - cfg.x_low;
    if (in_ch.raw_y < cfg.y_low)       cy_nxt = '0;
    else if (in_ch.raw_y > cfg.y_high) cy_nxt = cfg.y_high - cfg.y_low;
    else                               cy_nxt = in_ch.raw_y - cfg.y_low;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) begin
      s1_cx_r    <= cx_nxt;
      s1_cy_r    <= cy_nxt;
      s1_xspan_r <= cfg.x_high - cfg.x_low;
      s1_yspan_r <= cfg.y_high - cfg.y_low;
      s1_w_r     <= cfg.width;
      s1_h_r     <= cfg.height;
      s1_err_r   <= (cfg.x_high <= cfg.x_low) | (cfg.y_high <= cfg.y_low);
    end
  end

  assign prod_x = PROD_W'(s1_cx_r) * PROD_W'(s1_h_r);
  assign prod_y = PROD_W'(s1_cy_r) * PROD_W'(s1_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // the quotient never exceeds the screen size, so the top bits start below the divisor
  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      s2_item_r.lx.rem  <= prod_x[PROD_W-1:Q_W];
      s2_item_r.lx.lo   <= prod_x[Q_W-1:0];
      s2_item_r.lx.quo  <= '0;
      s2_item_r.lx.dvs  <= s1_xspan_r;
      s2_item_r.ly.rem  <= prod_y[PROD_W-1:Q_W];
      s2_item_r.ly.lo   <= prod_y[Q_W-1:0];
      s2_item_r.ly.quo  <= '0;
      s2_item_r.ly.dvs  <= s1_yspan_r;
      s2_item_r.height  <= s1_h_r;
      s2_item_r.err     <= s1_err_r;
    end
  end

  tpm_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(s2_vld_r),
    .up_ready(dv_rdy),
    .up_item (s2_item_r),
    .dn_valid(dv_vld),
    .dn_ready(o_rdy),
    .dn_item (dv_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= dv_vld;
    end
  end

  // y axis is inverted; a bad span forces both coordinates to zero
  always_ff @(posedge clk) begin
    if (o_rdy && dv_vld) begin
      o_err_r <= dv_item.err;
      if (dv_item.err) begin
        o_px_r <= '0;
        o_py_r <= '0;
      end else begin
        o_px_r <= dv_item.ly.quo;
        o_py_r <= dv_item.height - dv_item.lx.quo;
      end
    end
  end

  assign out_ch.valid      = o_vld_r;
  assign out_ch.pixel_x    = o_px_r;
  assign out_ch.pixel_y    = o_py_r;
  assign out_ch.span_error = o_err_r;

endmodule
